FILE: src/dedup_slot_table_defines.svh
// assertion macros for the dedup slot table
// no dependencies; included by files that carry concurrent assertions
`ifndef DEDUP_SLOT_TABLE_DEFINES_SVH
`define DEDUP_SLOT_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked property, disabled while reset is asserted
`define DST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, live through reset as well
`define DST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DST_ASSERT(lbl, clk, rst_n, prop, msg)
`define DST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/dst_pkg.sv
// shared types and codes for the dedup slot table
// no dependencies; imported by dedup_slot_table
package dst_pkg;

	localparam int MODE_W   = 2;
	localparam int KEYIN_W  = 32;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 9;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

	// result codes
	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SCAN   = 4'b0100,
		S_RDWAIT = 4'b1000
	} state_t;

endpackage

FILE: src/dst_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module dst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds when no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/dedup_slot_table.sv
// dedup slot table top level: sequencer, state registers and result register
// depends on dst_pkg, dst_ram and dedup_slot_table_defines.svh
`include "dedup_slot_table_defines.svh"
// usage
//   input channel (in_valid/in_ready) carries one beat per operation: mode, key,
//   slot_index. output channel (out_valid/out_ready) returns one beat per
//   operation: status, slot_out, key_out, live_count.
//   one operation at a time: in_ready is high only while the sequencer is idle.
//   the slot store is one RAM port pair; find, add and remove scan it from slot 0
//   upward one entry per cycle, with the compare in the cycle after the read.
//   zero key and bad slot results come from the decode step with no scan; read
//   returns the stored key from one store read. find and remove stop early on
//   a hit; add of a new key runs a key scan, then a hole scan, and appends at
//   the mark if no hole is found; a full table holds 256 slots by default.
//   the result register lets the next beat be taken while a result waits; if
//   the receiver stalls, the next operation finishes its scan and then holds
//   (no state changes) until the result register is free.
//   reset clears the mark, live count and sequencer; the store needs no clearing
//   since only slots below the mark are ever read.
module dedup_slot_table #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dst_pkg::MODE_W-1:0]    mode,
	input  logic [dst_pkg::KEYIN_W-1:0]   key,
	input  logic [dst_pkg::SLOT_W-1:0]    slot_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dst_pkg::STATUS_W-1:0]  status,
	output logic [dst_pkg::SLOT_W-1:0]    slot_out,
	output logic [dst_pkg::KEYIN_W-1:0]   key_out,
	output logic [dst_pkg::COUNT_W-1:0]   live_count
);

	import dst_pkg::*;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int MARK_W = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (MARK_W > SLOT_W) ? MARK_W : SLOT_W;

	// sequencer and table state
	state_t state_q, state_d;
	logic [MODE_W-1:0]   mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SLOT_W-1:0]   sidx_q;
	logic [MARK_W-1:0]   mark_q;
	logic [MARK_W-1:0]   live_q;
	logic [MARK_W-1:0]   ptr_q, ptr_d;
	logic [IDX_W-1:0]    pidx_q, pidx_d;
	logic                pend_q, pend_d;
	logic                hole_q, hole_d;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [KEY_BITS-1:0] kout_q;

	// store port
	logic                ram_we, ram_re;
	logic [IDX_W-1:0]    ram_waddr, ram_raddr;
	logic [KEY_BITS-1:0] ram_wdata, ram_rdata;

	// step outcome
	logic                emit;
	logic [STATUS_W-1:0] emit_status;
	logic [IDX_W-1:0]    emit_slot;
	logic [KEY_BITS-1:0] emit_kout;
	logic                mark_inc, live_inc, live_dec;

	logic                out_free, hit, more, slot_ok, key_zero, can_append;
	logic [KEY_BITS-1:0] target;

	dst_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free   = !out_valid_q || out_ready;
	// first scan looks for the key, second (add only) for a hole
	assign target     = hole_q ? '0 : key_q;
	// compare runs in the cycle after the read address is issued
	assign hit        = pend_q && (ram_rdata == target);
	assign more       = ptr_q < mark_q;
	assign slot_ok    = CMP_W'(sidx_q) < CMP_W'(mark_q);
	assign key_zero   = (key_q == '0);
	assign can_append = mark_q < MARK_W'(CAPACITY);

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		pidx_d      = pidx_q;
		pend_d      = pend_q;
		hole_d      = hole_q;
		ram_we      = 1'b0;
		ram_waddr   = pidx_q;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = ptr_q[IDX_W-1:0];
		emit        = 1'b0;
		emit_status = ST_NOT_FOUND;
		emit_slot   = '0;
		emit_kout   = '0;
		mark_inc    = 1'b0;
		live_inc    = 1'b0;
		live_dec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (mode_q == MODE_READ) begin
					if (slot_ok) begin
						ram_re    = 1'b1;
						ram_raddr = IDX_W'(sidx_q);
						state_d   = S_RDWAIT;
					end else if (out_free) begin
						emit        = 1'b1;
						emit_status = ST_BAD_SLOT;
						state_d     = S_IDLE;
					end
				end else if (key_zero) begin
					if (out_free) begin
						emit        = 1'b1;
						emit_status = ST_ZERO_KEY;
						state_d     = S_IDLE;
					end
				end else begin
					ptr_d   = '0;
					pend_d  = 1'b0;
					hole_d  = 1'b0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!hit && !more && !hole_q && mode_q == MODE_ADD) begin
					// new key: go look for the lowest hole
					ptr_d  = '0;
					pend_d = 1'b0;
					hole_d = 1'b1;
				end else if (hit || !more) begin
					if (out_free) begin
						emit    = 1'b1;
						pend_d  = 1'b0;
						state_d = S_IDLE;
						if (!hole_q) begin
							if (hit) begin
								emit_status = ST_HIT;
								emit_slot   = pidx_q;
								if (mode_q == MODE_REMOVE) begin
									ram_we    = 1'b1;
									ram_waddr = pidx_q;
									ram_wdata = '0;
									live_dec  = (live_q != '0);
								end
							end else begin
								emit_status = ST_NOT_FOUND;
							end
						end else if (hit) begin
							ram_we      = 1'b1;
							ram_waddr   = pidx_q;
							ram_wdata   = key_q;
							live_inc    = 1'b1;
							emit_status = ST_INSERTED;
							emit_slot   = pidx_q;
						end else if (can_append) begin
							ram_we      = 1'b1;
							ram_waddr   = mark_q[IDX_W-1:0];
							ram_wdata   = key_q;
							mark_inc    = 1'b1;
							live_inc    = 1'b1;
							emit_status = ST_INSERTED;
							emit_slot   = mark_q[IDX_W-1:0];
						end else begin
							emit_status = ST_FULL;
						end
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q[IDX_W-1:0];
					pidx_d    = ptr_q[IDX_W-1:0];
					ptr_d     = ptr_q + 1'b1;
					pend_d    = 1'b1;
				end
			end
			S_RDWAIT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_HIT;
					emit_kout   = ram_rdata;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mark_q      <= '0;
			live_q      <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			hole_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			pend_q  <= pend_d;
			hole_q  <= hole_d;
			if (mark_inc) begin
				mark_q <= mark_q + 1'b1;
			end
			if (live_inc) begin
				live_q <= live_q + 1'b1;
			end else if (live_dec) begin
				live_q <= live_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		pidx_q <= pidx_d;
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			key_q  <= KEY_BITS'(key);
			sidx_q <= slot_index;
		end
		if (emit) begin
			status_q <= emit_status;
			slot_q   <= SLOT_W'(emit_slot);
			kout_q   <= emit_kout;
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_out   = slot_q;
	assign key_out    = KEYIN_W'(kout_q);
	// live count only moves at the beat that loads the result register
	assign live_count = COUNT_W'(live_q);

	`DST_ASSERT(a_live_le_mark, clk, arst_n, live_q <= mark_q, "live count above mark")
	`DST_ASSERT(a_mark_in_range, clk, arst_n, mark_q <= MARK_W'(CAPACITY), "mark beyond capacity")
	`DST_ASSERT(a_mark_monotonic, clk, arst_n, mark_q >= $past(mark_q), "mark decreased")
	`DST_ASSERT(a_live_moves_with_result, clk, arst_n, !$stable(live_q) |-> out_valid_q, "live count changed without a result")
	`DST_ASSERT_ALWAYS(a_no_write_in_idle, clk, (state_q == S_IDLE) |-> !ram_we, "store written while idle")

endmodule
